@@ rtl/core/ordf_pkg.sv @@
// Shared types and constants for the object record deframer.
package ordf_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int BUF_AW       = $clog2(BUFFER_DEPTH);
    localparam int RAM_DEPTH    = 2 * BUFFER_DEPTH;
    localparam int RAM_AW       = BUF_AW + 1;
    localparam int LEN_W        = 7;
    localparam int IDX_W        = 6;
    localparam int HDR_LEN      = 6;
    localparam int CMDQ_DEPTH   = 2;
    localparam int CMDQ_AW      = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW      = $clog2(CMDQ_DEPTH + 1);
    localparam int OQ_DEPTH     = 4;
    localparam int OQ_AW        = $clog2(OQ_DEPTH);
    localparam int OQ_CW        = $clog2(OQ_DEPTH + 1);

    localparam logic [7:0]       LEAD_BYTE       = 8'h01;
    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = LEN_W'(40);

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_CSUM = 2'd1,
        ST_LEAD = 2'd2,
        ST_SIZE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        PH_LEAD    = 3'd0,
        PH_HUNT    = 3'd1,
        PH_HEADER  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CHECK   = 3'd4,
        PH_PAD     = 3'd5
    } t_phase;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_RUN  = 1'b1
    } t_bk_state;

    typedef struct packed {
        t_status          status;
        logic [7:0]       rtype;
        logic [LEN_W-1:0] len;
        logic             bank;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_rel;

    typedef struct packed {
        logic              we;
        logic [RAM_AW-1:0] addr;
        logic [7:0]        data;
    } t_ramwr;

    typedef struct packed {
        logic [7:0]       rtype;
        logic [7:0]       pbyte;
        logic             pvalid;
        logic [IDX_W-1:0] idx;
        logic             last;
        t_status          status;
    } t_result;

endpackage

@@ rtl/core/ordf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ordf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/core/ordf_front.sv @@
// Record parser: takes stream bytes, fills payload banks, issues delivery commands.
module ordf_front import ordf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [7:0]       i_data_byte,
    input  logic [LEN_W-1:0] i_max_payload,
    input  logic             i_cmd_full,
    input  t_rel             i_rel,
    output logic             o_full,
    output logic             o_cmd_push,
    output t_cmd             o_cmd,
    output t_ramwr           o_ramwr
);

    localparam logic [LEN_W-1:0] HB_LEN_LO = LEN_W'(1);
    localparam logic [LEN_W-1:0] HB_LEN_HI = LEN_W'(2);
    localparam logic [LEN_W-1:0] HB_TYPE   = LEN_W'(3);
    localparam logic [LEN_W-1:0] HB_LAST   = LEN_W'(4);

    t_phase           r_phase, n_phase;
    logic [7:0]       r_len_lo;
    logic [LEN_W-1:0] r_plen;
    logic [LEN_W-1:0] r_fill;
    logic [7:0]       r_type;
    logic [7:0]       r_sum;
    logic             r_bank;
    logic [1:0]       r_busy;

    logic             accept;
    logic [7:0]       sum_nxt;
    logic [15:0]      total;
    logic [LEN_W-1:0] limit;
    logic             size_err;
    logic             last_fill;
    logic             commit;
    logic [1:0]       rel_mask;
    logic [1:0]       set_mask;

    assign o_full    = i_cmd_full || (r_phase == PH_PAYLOAD && r_busy[r_bank]);
    assign accept    = i_push && !o_full;
    assign sum_nxt   = r_sum + i_data_byte;
    assign total     = {i_data_byte, r_len_lo};
    assign limit     = (i_max_payload > LEN_W'(BUFFER_DEPTH)) ? LEN_W'(BUFFER_DEPTH)
                                                            : i_max_payload;
    assign size_err  = (total < 16'(HDR_LEN)) || ((total - 16'(HDR_LEN)) > 16'(limit));
    assign last_fill = (r_fill + LEN_W'(1)) >= r_plen;
    assign commit    = accept && r_phase == PH_CHECK && sum_nxt == 8'h00 && r_plen != '0;
    assign rel_mask  = i_rel.valid ? (2'b01 << i_rel.bank) : 2'b00;
    assign set_mask  = commit ? (2'b01 << r_bank) : 2'b00;

    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            unique case (r_phase)
                PH_LEAD, PH_HUNT: begin
                    n_phase = (i_data_byte == LEAD_BYTE) ? PH_HEADER : PH_HUNT;
                end
                PH_HEADER: begin
                    if (r_fill == HB_LEN_HI && size_err) begin
                        n_phase = PH_HUNT;
                    end else if (r_fill == HB_LAST) begin
                        n_phase = (r_plen == '0) ? PH_CHECK : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (last_fill) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    if (sum_nxt != 8'h00) begin
                        n_phase = PH_HUNT;
                    end else begin
                        n_phase = r_plen[0] ? PH_LEAD : PH_PAD;
                    end
                end
                PH_PAD:  n_phase = PH_LEAD;
                default: n_phase = PH_HUNT;
            endcase
        end
    end

    always_comb begin
        o_cmd_push    = 1'b0;
        o_cmd.status  = ST_OK;
        o_cmd.rtype   = 8'h00;
        o_cmd.len     = '0;
        o_cmd.bank    = r_bank;
        o_ramwr.we    = 1'b0;
        o_ramwr.addr  = {r_bank, r_fill[BUF_AW-1:0]};
        o_ramwr.data  = i_data_byte;
        unique case (r_phase)
            PH_LEAD: begin
                if (accept && i_data_byte != LEAD_BYTE) begin
                    o_cmd_push   = 1'b1;
                    o_cmd.status = ST_LEAD;
                end
            end
            PH_HEADER: begin
                if (accept && r_fill == HB_LEN_HI && size_err) begin
                    o_cmd_push   = 1'b1;
                    o_cmd.status = ST_SIZE;
                end
            end
            PH_PAYLOAD: begin
                o_ramwr.we = accept;
            end
            PH_CHECK: begin
                o_cmd_push   = accept;
                o_cmd.status = (sum_nxt != 8'h00) ? ST_CSUM : ST_OK;
                o_cmd.rtype  = r_type;
                o_cmd.len    = r_plen;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LEAD;
            r_len_lo <= '0;
            r_plen   <= '0;
            r_fill   <= '0;
            r_type   <= '0;
            r_sum    <= '0;
            r_bank   <= 1'b0;
            r_busy   <= '0;
        end else begin
            r_phase <= n_phase;
            r_busy  <= (r_busy & ~rel_mask) | set_mask;
            if (commit) begin
                r_bank <= ~r_bank;
            end
            if (accept) begin
                case (r_phase)
                    PH_LEAD, PH_HUNT: begin
                        if (i_data_byte == LEAD_BYTE) begin
                            r_sum  <= LEAD_BYTE;
                            r_fill <= '0;
                        end
                    end
                    PH_HEADER: begin
                        r_sum <= sum_nxt;
                        case (r_fill)
                            HB_LEN_LO: r_len_lo <= i_data_byte;
                            HB_LEN_HI: r_plen   <= LEN_W'(total - 16'(HDR_LEN));
                            HB_TYPE:   r_type   <= i_data_byte;
                            default: ;
                        endcase
                        r_fill <= (r_fill == HB_LAST) ? '0 : r_fill + LEN_W'(1);
                    end
                    PH_PAYLOAD: begin
                        r_sum  <= sum_nxt;
                        r_fill <= r_fill + LEN_W'(1);
                    end
                    PH_CHECK: begin
                        r_sum <= sum_nxt;
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ rtl/core/ordf_cmd_fifo.sv @@
// Short command queue between the parser and the delivery engine.
module ordf_cmd_fifo import ordf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd               r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_wp;
    logic [CMDQ_AW-1:0] r_rp;
    logic [CMDQ_CW-1:0] r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = r_cnt == CMDQ_CW'(CMDQ_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + CMDQ_AW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + CMDQ_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CMDQ_CW'(1);
            end else if (!do_push && do_pop) begin
                r_cnt <= r_cnt - CMDQ_CW'(1);
            end
        end
    end

endmodule

@@ rtl/core/ordf_back.sv @@
// Delivery engine: reads buffered payload and queues result transactions.
module ordf_back import ordf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_empty,
    input  t_cmd              i_cmd,
    output logic              o_cmd_pop,
    output logic [RAM_AW-1:0] o_raddr,
    input  logic [7:0]        i_rdata,
    output t_rel              o_rel,
    input  logic              i_pop,
    output logic              o_empty,
    output t_result           o_res
);

    t_bk_state         r_state, n_state;
    t_cmd              r_cmd;
    logic [BUF_AW-1:0] r_k;
    logic              r_p_valid;
    t_result           r_p;
    t_result           r_q [OQ_DEPTH];
    logic [OQ_AW-1:0]  r_wp;
    logic [OQ_AW-1:0]  r_rp;
    logic [OQ_CW-1:0]  r_cnt;

    logic              can_issue;
    logic              single;
    logic              last_k;
    logic              issue;
    t_result           iss;
    t_result           push_res;
    logic              out_pop;

    assign can_issue = (r_cnt + OQ_CW'(r_p_valid)) < OQ_CW'(OQ_DEPTH);
    assign single    = (i_cmd.status != ST_OK) || (i_cmd.len == '0);
    assign last_k    = (LEN_W'(r_k) + LEN_W'(1)) == r_cmd.len;
    assign o_empty   = r_cnt == '0;
    assign o_res     = r_q[r_rp];
    assign out_pop   = i_pop && !o_empty;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_cmd_empty && can_issue && !single) begin
                    n_state = BK_RUN;
                end
            end
            BK_RUN: begin
                if (can_issue && last_k) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop   = 1'b0;
        issue       = 1'b0;
        iss.rtype   = i_cmd.rtype;
        iss.pbyte   = 8'h00;
        iss.pvalid  = 1'b0;
        iss.idx     = '0;
        iss.last    = 1'b1;
        iss.status  = i_cmd.status;
        o_raddr     = {r_cmd.bank, r_k};
        o_rel.valid = 1'b0;
        o_rel.bank  = r_cmd.bank;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_cmd_empty && can_issue) begin
                    o_cmd_pop = 1'b1;
                    issue     = single;
                end
            end
            BK_RUN: begin
                if (can_issue) begin
                    issue       = 1'b1;
                    iss.rtype   = r_cmd.rtype;
                    iss.pvalid  = 1'b1;
                    iss.idx     = IDX_W'(r_k);
                    iss.last    = last_k;
                    iss.status  = ST_OK;
                    o_rel.valid = last_k;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        push_res       = r_p;
        push_res.pbyte = r_p.pvalid ? i_rdata : 8'h00;
    end

    always_ff @(posedge i_clk) begin
        r_p <= iss;
        if (o_cmd_pop && !single) begin
            r_cmd <= i_cmd;
        end
        if (r_p_valid) begin
            r_q[r_wp] <= push_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_k       <= '0;
            r_p_valid <= 1'b0;
            r_wp      <= '0;
            r_rp      <= '0;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_p_valid <= issue;
            if (o_cmd_pop && !single) begin
                r_k <= '0;
            end else if (r_state == BK_RUN && can_issue) begin
                r_k <= r_k + BUF_AW'(1);
            end
            if (r_p_valid) begin
                r_wp <= r_wp + OQ_AW'(1);
            end
            if (out_pop) begin
                r_rp <= r_rp + OQ_AW'(1);
            end
            if (r_p_valid && !out_pop) begin
                r_cnt <= r_cnt + OQ_CW'(1);
            end else if (!r_p_valid && out_pop) begin
                r_cnt <= r_cnt - OQ_CW'(1);
            end
        end
    end

endmodule

@@ rtl/core/object_record_deframer_core.sv @@
// Top level of the object record deframer: parser, command queue, delivery, payload RAM.
//
// Bytes are taken one per cycle whenever full is low. A record's payload is stored in one
// of two RAM banks of 64 bytes; on a good checksum byte the record is handed to the
// delivery engine, which puts out one payload result per cycle while the four-entry result
// queue has room; the next record is parsed while the previous one drains. Errors and
// empty records give one result. full rises while the two-entry command queue is full, or
// while payload bytes arrive for a bank whose earlier record has not finished draining;
// the sustained rate is then set by the RAM read port, one payload byte per cycle out
// while the result queue has room. A payload run's first result goes through the command
// queue, RUN state, result register and result queue; error and empty results skip RUN.
module object_record_deframer_core import ordf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  logic [7:0]       i_data_byte,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_data,
    output logic             empty,
    input  logic             pop,
    output logic [7:0]       o_record_type,
    output logic [7:0]       o_payload_byte,
    output logic             o_payload_valid,
    output logic [IDX_W-1:0] o_byte_index,
    output logic             o_last,
    output logic [1:0]       o_status
);

    logic [LEN_W-1:0]  r_max_payload;
    logic              cmd_push;
    t_cmd              cmd_in;
    logic              cmd_full;
    logic              cmd_pop;
    logic              cmd_empty;
    t_cmd              cmd_out;
    t_rel              rel;
    t_ramwr            ramwr;
    logic [RAM_AW-1:0] raddr;
    logic [7:0]        rdata;
    t_result           res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RST;
        end else if (i_cfg_we) begin
            r_max_payload <= i_cfg_data;
        end
    end

    ordf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_data_byte   (i_data_byte),
        .i_max_payload (r_max_payload),
        .i_cmd_full    (cmd_full),
        .i_rel         (rel),
        .o_full        (full),
        .o_cmd_push    (cmd_push),
        .o_cmd         (cmd_in),
        .o_ramwr       (ramwr)
    );

    ordf_cmd_fifo u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_cmd   (cmd_out)
    );

    ordf_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ramwr.we),
        .i_waddr (ramwr.addr),
        .i_wdata (ramwr.data),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    ordf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_rel       (rel),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (res)
    );

    assign o_record_type   = res.rtype;
    assign o_payload_byte  = res.pbyte;
    assign o_payload_valid = res.pvalid;
    assign o_byte_index    = res.idx;
    assign o_last          = res.last;
    assign o_status        = res.status;

    a_cmd_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_push |-> !cmd_full)
        else $error("command pushed into a full queue");

    a_single_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_payload_valid) |-> o_last)
        else $error("dataless transaction without last");

    a_error_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != ST_OK) |-> (!o_payload_valid && o_payload_byte == 8'h00))
        else $error("error transaction carries payload");

    a_no_write_busy_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ramwr.we && rel.valid) |-> (ramwr.addr[RAM_AW-1] != rel.bank))
        else $error("payload write into bank being drained");

endmodule
